[hdl/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared widths, reciprocal constants and pipeline control types for the
// hsl to rgb565 converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W   = 15;
    localparam int SL_W    = 13;
    localparam int RGB_W   = 16;
    localparam int CH8_W   = 8;
    localparam int NUM_CH  = 3;
    localparam int HUE_MAX = (1 << HUE_W) - 1;

    // register stages from input to output
    localparam int H2R_STAGES = 7;

    // floor(x / 60) = (x * RECIP60_M) >> RECIP60_SH, exact for x below 2^16
    localparam int               RECIP60_W  = 16;
    localparam logic [15:0]      RECIP60_M  = 16'd34953;
    localparam int               RECIP60_SH = 21;

    // floor(x / 6) = (x * RECIP6_M) >> RECIP6_SH, exact for x below 2^11
    localparam int               RECIP6_W   = 10;
    localparam logic [9:0]       RECIP6_M   = 10'd683;
    localparam int               RECIP6_SH  = 12;

    // floor(x / 15) = (x * RECIP15_M) >> RECIP15_SH, exact for x below 2^12
    localparam int               RECIP15_W  = 13;
    localparam logic [12:0]      RECIP15_M  = 13'd4370;
    localparam int               RECIP15_SH = 16;

    // rounded channel value before the final divide by 15
    localparam int               P_W   = 12;
    localparam logic [P_W-1:0]   P_MAX = 12'd3832;

    typedef struct packed {
        logic [H2R_STAGES-1:0] load;
        logic [H2R_STAGES-1:0] valid;
    } t_pipe_ctl;

endpackage

[hdl/hsl_to_rgb565_converter_top.sv]
// ----------------------------------------------------------------------------
// hsl_to_rgb565_converter_top
// Converts hue, saturation and lightness into a packed rgb565 pixel using
// exact fixed point and one round-half-up step per channel.
//
//   channel   signals                                       dir
//   input     i_valid, o_stall, i_hue, i_saturation,        in
//             i_lightness
//   output    o_valid, i_stall, o_rgb565                    out
//
// One item per clock sustained while i_stall is low; there are seven register
// stages, the last one being the output register.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall holds the output register; earlier stages keep filling empty
// slots, and o_stall rises only once all seven stages hold an item.
// ----------------------------------------------------------------------------
module hsl_to_rgb565_converter_top
    import h2r_pkg::*;
#(
    parameter int UNIT_FRAC_BITS = 12,
    parameter int HUE_FRAC_BITS  = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [SL_W-1:0]  i_saturation,
    input  logic [SL_W-1:0]  i_lightness,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [RGB_W-1:0] o_rgb565
);

    localparam int UW      = UNIT_FRAC_BITS + 1;
    localparam int CW      = 2 * UNIT_FRAC_BITS + 1;
    localparam int MCW     = 2 * UNIT_FRAC_BITS + 2;
    localparam int HW      = HUE_FRAC_BITS + 6;
    localparam int SH      = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 3;
    localparam int VW      = SH + 4;
    localparam int NW      = VW + CH8_W;
    localparam int H60     = 60 << HUE_FRAC_BITS;
    localparam int Q60_MAX = (HUE_MAX >> HUE_FRAC_BITS) / 60;
    localparam int QW      = (Q60_MAX < 2) ? 1 : $clog2(Q60_MAX + 1);

    localparam logic [UW-1:0]  UNIT_ONE = UW'(1) << UNIT_FRAC_BITS;
    localparam logic [HW-1:0]  H60_K    = HW'(H60);
    localparam logic [VW-1:0]  CV_K     = VW'(2 * H60);
    localparam logic [VW-1:0]  MV_K     = VW'(H60);
    localparam logic [NW-1:0]  HALF_DEN = NW'(15) << (SH - 1);
    localparam logic [MCW-1:0] MC_MAX   = MCW'(1) << (2 * UNIT_FRAC_BITS + 1);

    typedef enum logic [2:0] {
        SEXT_RY,
        SEXT_YG,
        SEXT_GC,
        SEXT_CB,
        SEXT_BM,
        SEXT_MR
    } t_sext;

    t_pipe_ctl ctl;

    h2r_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_ctl   (ctl)
    );

    // ---------------- stage 1: clamp, distance from mid grey, hue / 60 deg
    logic [HUE_W-1:0]           hue_hi;
    logic [HUE_W+RECIP60_W-1:0] q60_prod;
    logic [UW-1:0]              s_c;
    logic [UW-1:0]              l_c;
    logic [UW:0]                two_l;
    logic [UW:0]                l_dev;
    logic [QW-1:0]              n1_q60;
    logic [UW-1:0]              n1_a;

    logic [HUE_W-1:0] r1_hue;
    logic [QW-1:0]    r1_q60;
    logic [UW-1:0]    r1_a;
    logic [UW-1:0]    r1_s;
    logic [UW-1:0]    r1_l;

    always_comb begin
        hue_hi   = i_hue >> HUE_FRAC_BITS;
        q60_prod = hue_hi * RECIP60_M;
        n1_q60   = QW'(q60_prod >> RECIP60_SH);
        s_c      = (i_saturation > UNIT_ONE) ? UNIT_ONE : UW'(i_saturation);
        l_c      = (i_lightness > UNIT_ONE) ? UNIT_ONE : UW'(i_lightness);
        two_l    = {l_c, 1'b0};
        if (two_l >= (UW + 1)'(UNIT_ONE)) begin
            l_dev = two_l - (UW + 1)'(UNIT_ONE);
        end else begin
            l_dev = (UW + 1)'(UNIT_ONE) - two_l;
        end
        n1_a = UW'((UW + 1)'(UNIT_ONE) - l_dev);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r1_hue <= i_hue;
            r1_q60 <= n1_q60;
            r1_a   <= n1_a;
            r1_s   <= s_c;
            r1_l   <= l_c;
        end
    end

    // ---------------- stage 2: chroma, position within the sextant
    logic [2*UW-1:0]           c_prod;
    logic [HUE_W-1:0]          base60;
    logic [HW-1:0]             rem;
    logic [HW-1:0]             n2_t;
    logic [QW+RECIP6_W-1:0]    q6_prod;

    logic [CW-1:0] r2_cnum;
    logic [HW-1:0] r2_t;
    logic [QW-1:0] r2_q60;
    logic [QW-1:0] r2_q6;
    logic [UW-1:0] r2_l;

    always_comb begin
        c_prod  = r1_a * r1_s;
        base60  = HUE_W'(r1_q60 * H60_K);
        rem     = HW'(r1_hue - base60);
        // odd sextants count down towards the next primary
        n2_t    = r1_q60[0] ? (H60_K - rem) : rem;
        q6_prod = r1_q60 * RECIP6_M;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[1]) begin
            r2_cnum <= CW'(c_prod);
            r2_t    <= n2_t;
            r2_q60  <= r1_q60;
            r2_q6   <= QW'(q6_prod >> RECIP6_SH);
            r2_l    <= r1_l;
        end
    end

    // ---------------- stage 3: lightness offset core, sextant index
    logic [QW+2:0] sext_w;

    logic [CW-1:0]  r3_cnum;
    logic [HW-1:0]  r3_t;
    logic [MCW-1:0] r3_mcore;
    t_sext          r3_sext;

    always_comb begin
        sext_w = (QW + 3)'(r2_q60) - (QW + 3)'(r2_q6) * (QW + 3)'(6);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[2]) begin
            r3_cnum  <= r2_cnum;
            r3_t     <= r2_t;
            r3_mcore <= (MCW'(r2_l) << (UNIT_FRAC_BITS + 1)) - MCW'(r2_cnum);
            r3_sext  <= t_sext'(sext_w[2:0]);
        end
    end

    // ---------------- stage 4: scale chroma, secondary and offset
    logic [CW+HW-1:0] x_prod;

    logic [VW-1:0] r4_cv;
    logic [VW-1:0] r4_xv;
    logic [VW-1:0] r4_mv;
    t_sext         r4_sext;

    always_comb begin
        x_prod = r3_cnum * r3_t;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[3]) begin
            r4_cv   <= VW'(r3_cnum) * CV_K;
            r4_xv   <= VW'({x_prod, 1'b0});
            r4_mv   <= VW'(r3_mcore) * MV_K;
            r4_sext <= r3_sext;
        end
    end

    // ---------------- stage 5: place components on channels, add offset
    logic [VW-1:0] k_ch [NUM_CH];
    logic [VW-1:0] r5_v [NUM_CH];

    always_comb begin
        case (r4_sext)
            SEXT_RY: begin
                k_ch[0] = r4_cv; k_ch[1] = r4_xv; k_ch[2] = '0;
            end
            SEXT_YG: begin
                k_ch[0] = r4_xv; k_ch[1] = r4_cv; k_ch[2] = '0;
            end
            SEXT_GC: begin
                k_ch[0] = '0;    k_ch[1] = r4_cv; k_ch[2] = r4_xv;
            end
            SEXT_CB: begin
                k_ch[0] = '0;    k_ch[1] = r4_xv; k_ch[2] = r4_cv;
            end
            SEXT_BM: begin
                k_ch[0] = r4_xv; k_ch[1] = '0;    k_ch[2] = r4_cv;
            end
            default: begin
                k_ch[0] = r4_cv; k_ch[1] = '0;    k_ch[2] = r4_xv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[4]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r5_v[c] <= k_ch[c] + r4_mv;
            end
        end
    end

    // ---------------- stage 6: times 255 plus half, drop the power of two
    logic [NW-1:0]  w_ch [NUM_CH];
    logic [P_W-1:0] r6_p [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_ch[c] = {r5_v[c], 8'b0} - NW'(r5_v[c]) + HALF_DEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[5]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r6_p[c] <= w_ch[c][SH +: P_W];
            end
        end
    end

    // ---------------- stage 7: divide by 15, saturate, pack
    logic [P_W+RECIP15_W-1:0] d_prod [NUM_CH];
    logic [CH8_W:0]           q9     [NUM_CH];
    logic [CH8_W-1:0]         ch8    [NUM_CH];
    logic [RGB_W-1:0]         r7_rgb565;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            d_prod[c] = r6_p[c] * RECIP15_M;
            q9[c]     = d_prod[c][RECIP15_SH +: CH8_W + 1];
            ch8[c]    = q9[c][CH8_W] ? '1 : q9[c][CH8_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[6]) begin
            r7_rgb565 <= {ch8[0][7:3], ch8[1][7:2], ch8[2][7:3]};
        end
    end

    assign o_rgb565 = r7_rgb565;
    assign o_valid  = ctl.valid[H2R_STAGES-1];

    // reciprocal divide by six must land on the true quotient
    a_sext_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.valid[1] |-> ((r2_q60 >= r2_q6 * 6) && (r2_q60 < r2_q6 * 6 + 6)))
        else $error("sextant quotient out of range");

    a_hue_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.valid[1] |-> (r2_t <= H60_K))
        else $error("hue offset beyond one sextant");

    a_offset_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.valid[2] |-> (r3_mcore <= MC_MAX))
        else $error("lightness offset out of range");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.valid[5] |-> ((r6_p[0] <= P_MAX) && (r6_p[1] <= P_MAX) && (r6_p[2] <= P_MAX)))
        else $error("rounded channel exceeds full scale");

endmodule

[hdl/h2r_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// h2r_pipe_ctrl
// Valid bits and load enables for the converter pipeline; empty stages are
// filled while the output is stalled, so bubbles squeeze out.
// ----------------------------------------------------------------------------
module h2r_pipe_ctrl
    import h2r_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_stall,
    output logic      o_stall,
    output t_pipe_ctl o_ctl
);

    logic [H2R_STAGES-1:0] r_valid;
    logic [H2R_STAGES-1:0] n_valid;
    logic [H2R_STAGES:0]   rdy;

    always_comb begin
        rdy[H2R_STAGES] = !i_stall;
        for (int k = H2R_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
        n_valid[0] = rdy[0] ? i_valid : r_valid[0];
        for (int k = 1; k < H2R_STAGES; k++) begin
            n_valid[k] = rdy[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall     = !rdy[0];
    assign o_ctl.load  = rdy[H2R_STAGES-1:0];
    assign o_ctl.valid = r_valid;

    // upstream only waits when every stage holds an item and the output is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_valid) && i_stall))
        else $error("input stalled with a free stage in the pipeline");

    a_empty_stage_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0] |-> rdy[0])
        else $error("empty first stage not loading");

    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[H2R_STAGES-1] && i_stall) |=> r_valid[H2R_STAGES-1])
        else $error("stalled output item dropped");

endmodule

[sim/tb_hsl_to_rgb565_converter_top.sv]
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb565_converter_top
// Self-checking bench for the hsl to rgb565 converter. Pixels are streamed
// through a valid/stall driver and checked against an exact fixed point
// model of the conversion, in order. The run has four phases: no idling,
// a sparse sender, a stalling receiver, and both at once.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb565_converter_top;
    import h2r_pkg::*;

    localparam int UNIT_FRAC_BITS = 12;
    localparam int HUE_FRAC_BITS  = 6;
    localparam int UNIT_ONE       = 1 << UNIT_FRAC_BITS;
    localparam int HUE_60         = 60 << HUE_FRAC_BITS;
    localparam int HUE_360        = 360 << HUE_FRAC_BITS;
    localparam int RANDOM_PER_PHASE = 100;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SL_W-1:0]  sat;
        logic [SL_W-1:0]  light;
    } t_pixel;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic             o_stall;
    logic [HUE_W-1:0] i_hue        = '0;
    logic [SL_W-1:0]  i_saturation = '0;
    logic [SL_W-1:0]  i_lightness  = '0;
    logic             o_valid;
    logic             i_stall      = 1'b0;
    logic [RGB_W-1:0] o_rgb565;

    t_pixel           pending_pixels [$];
    logic [RGB_W-1:0] expected_rgb [$];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               mismatches = 0;

    hsl_to_rgb565_converter_top #(
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS),
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_lightness (i_lightness),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rgb565    (o_rgb565)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exact conversion: every value counts 1/den, one rounding per channel
    function automatic logic [RGB_W-1:0] pixel_to_565(t_pixel px);
        longint unsigned den, hue, s, l, l_dev, chroma, sext, rem, t, cv, xv, mv, q;
        longint unsigned ch [NUM_CH];
        logic [CH8_W-1:0] ch8 [NUM_CH];
        den  = 2 * longint'(UNIT_ONE) * UNIT_ONE * HUE_60;
        hue  = px.hue % HUE_360;
        s    = (px.sat > UNIT_ONE) ? UNIT_ONE : px.sat;
        l    = (px.light > UNIT_ONE) ? UNIT_ONE : px.light;
        l_dev = (2 * l >= UNIT_ONE) ? (2 * l - UNIT_ONE) : (UNIT_ONE - 2 * l);
        chroma = (UNIT_ONE - l_dev) * s;
        sext = hue / HUE_60;
        rem  = hue % HUE_60;
        t    = sext[0] ? (HUE_60 - rem) : rem;
        cv   = chroma * 2 * HUE_60;
        xv   = chroma * 2 * t;
        mv   = l * 2 * UNIT_ONE * HUE_60 - chroma * HUE_60;
        case (sext)
            0: begin ch[0] = cv; ch[1] = xv; ch[2] = 0;  end
            1: begin ch[0] = xv; ch[1] = cv; ch[2] = 0;  end
            2: begin ch[0] = 0;  ch[1] = cv; ch[2] = xv; end
            3: begin ch[0] = 0;  ch[1] = xv; ch[2] = cv; end
            4: begin ch[0] = xv; ch[1] = 0;  ch[2] = cv; end
            default: begin ch[0] = cv; ch[1] = 0; ch[2] = xv; end
        endcase
        for (int k = 0; k < NUM_CH; k++) begin
            q = ((ch[k] + mv) * 255 + den / 2) / den;
            ch8[k] = (q > 255) ? 8'd255 : q[CH8_W-1:0];
        end
        return {ch8[0][7:3], ch8[1][7:2], ch8[2][7:3]};
    endfunction

    task automatic report_mismatch(string what, logic [RGB_W-1:0] want, logic [RGB_W-1:0] got);
        $display("mismatch: %s expected %h got %h at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    task automatic queue_pixel(int hue, int sat, int light);
        t_pixel px;
        px.hue   = HUE_W'(hue);
        px.sat   = SL_W'(sat);
        px.light = SL_W'(light);
        pending_pixels.push_back(px);
    endtask

    task automatic queue_random_pixel();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            queue_pixel($urandom_range(HUE_360 - 1), $urandom_range(UNIT_ONE),
                        $urandom_range(UNIT_ONE));
        end else if (pick < 85) begin
            // near sextant boundaries, the ends of the saturation range and mid or full lightness
            queue_pixel(HUE_60 * $urandom_range(6) + $urandom_range(2) - 1 + 1,
                        $urandom_range(1) ? UNIT_ONE - $urandom_range(1) : $urandom_range(1),
                        $urandom_range(1) ? UNIT_ONE / 2 + $urandom_range(2) - 1
                                          : UNIT_ONE - $urandom_range(1));
        end else begin
            // any bit pattern, including wrapped hue and clamped s/l
            queue_pixel($urandom_range(HUE_MAX), $urandom_range((1 << SL_W) - 1),
                        $urandom_range((1 << SL_W) - 1));
        end
    endtask

    // driver: holds an item until accepted, then maybe presents the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_rgb.push_back(pixel_to_565({i_hue, i_saturation, i_lightness}));
            end
            if (!i_valid || !o_stall) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_pixel px;
                    px = pending_pixels.pop_front();
                    i_valid      <= 1'b1;
                    i_hue        <= px.hue;
                    i_saturation <= px.sat;
                    i_lightness  <= px.light;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rgb.size() == 0) begin
                report_mismatch("unexpected item,", '0, o_rgb565);
            end else begin
                logic [RGB_W-1:0] want;
                want = expected_rgb.pop_front();
                if (o_rgb565 !== want) begin
                    report_mismatch("rgb565", want, o_rgb565);
                end
            end
        end
    end

    initial begin
        int idle_set  [4];
        int stall_set [4];
        int corner_hues [9];
        idle_set  = '{0, 86, 0, 22};
        stall_set = '{0, 0, 86, 22};
        corner_hues = '{0, 1920, HUE_60 - 1, HUE_60, 2 * HUE_60, 3 * HUE_60, 4 * HUE_60,
                        5 * HUE_60, HUE_360 - 1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sextant edges at full saturation, mid lightness
        foreach (corner_hues[k]) begin
            queue_pixel(corner_hues[k], UNIT_ONE, UNIT_ONE / 2);
        end
        // hue of a full turn and above wraps round
        queue_pixel(HUE_360, UNIT_ONE, UNIT_ONE / 2);
        queue_pixel(27000, 2000, 3000);
        queue_pixel(HUE_MAX, UNIT_ONE, UNIT_ONE / 2);
        // grey, black, white and clamped s/l
        queue_pixel(5000, 0, UNIT_ONE / 2);
        queue_pixel(5000, (1 << SL_W) - 1, UNIT_ONE / 2);
        queue_pixel(9000, UNIT_ONE, 0);
        queue_pixel(9000, UNIT_ONE, UNIT_ONE);
        queue_pixel(9000, UNIT_ONE, (1 << SL_W) - 1);
        queue_pixel(16384, UNIT_ONE - 1, UNIT_ONE / 2 - 1);
        queue_pixel(16384, 1, 1);
        queue_pixel(12000, UNIT_ONE, UNIT_ONE - 1);
        queue_pixel(0, 0, 0);
        queue_pixel(HUE_MAX, (1 << SL_W) - 1, (1 << SL_W) - 1);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            repeat (RANDOM_PER_PHASE) queue_random_pixel();
            while (pending_pixels.size() > 0 || i_valid) @(negedge i_clk);
        end

        while (expected_rgb.size() > 0) @(negedge i_clk);
        repeat (3 * H2R_STAGES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[hsl_to_rgb565_converter_top] OK");
        end else begin
            $display("[hsl_to_rgb565_converter_top] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[hsl_to_rgb565_converter_top] ERROR");
        $finish;
    end

endmodule
